FILE: src/cmdkw_pkg.sv
// Shared types and constants for the command keyword parser.
package cmdkw_pkg;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_UPTIME = 3'd1,
    MODE_LOAD   = 3'd2,
    MODE_DIGIT  = 3'd3,
    MODE_EXIT   = 3'd4
  } mode_t;

  // Characters recognised by the parser
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [30:0] SUM_MAX = 31'h7FFF_FFFF;

  // Configuration port
  localparam int unsigned     PADDR_W            = 3;
  localparam logic            REG_STRIKE_LIMIT   = 1'b0;  // register select, paddr[2]
  localparam logic [2:0]      STRIKE_LIMIT_RESET = 3'd2;

  // Reply queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = 2;
  localparam int unsigned CNT_W       = 3;
  localparam logic [CNT_W-1:0] PUSH_ROOM = CNT_W'(QUEUE_DEPTH - 2);

  typedef struct packed {
    logic signed [31:0] reply_code;
    logic               close_session;
    logic               last_reply;
  } result_t;

  // Results produced by one accepted byte
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

FILE: src/cmdkw_rx_if.sv
// Input byte channel.
interface cmdkw_rx_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [30:0] uptime_seconds;
  logic [15:0] connection_count;

  modport source (output valid, output rx_byte, output uptime_seconds,
                  output connection_count, input ready);
  modport sink   (input valid, input rx_byte, input uptime_seconds,
                  input connection_count, output ready);
endinterface

FILE: src/cmdkw_reply_if.sv
// Reply channel.
interface cmdkw_reply_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] reply_code;
  logic               close_session;
  logic               last_reply;

  modport source (output valid, output reply_code, output close_session,
                  output last_reply, input ready);
  modport sink   (input valid, input reply_code, input close_session,
                  input last_reply, output ready);
endinterface

FILE: src/cmdkw_regs.sv
// APB configuration register: strike limit.
module cmdkw_regs
  import cmdkw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [2:0]         strike_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_STRIKE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      strike_limit <= STRIKE_LIMIT_RESET;
    end else if (wr_en) begin
      strike_limit <= pwdata[2:0];
    end
  end

  assign prdata = (paddr[2] == REG_STRIKE_LIMIT) ? {29'd0, strike_limit} : 32'd0;

endmodule

FILE: src/cmdkw_parser.sv
// Byte parser: mode, match position, digit sum, strikes and session state.
module cmdkw_parser
  import cmdkw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic [30:0] uptime_seconds,
  input  logic [15:0] connection_count,
  input  logic [2:0]  strike_limit,
  output push_t       push
);

  typedef struct packed {
    logic       closing;
    logic [2:0] count;
  } strike_t;

  mode_t       mode, mode_next;
  logic [2:0]  pos, pos_next;
  logic [30:0] total, total_next;
  logic [2:0]  strikes, strikes_next;
  logic        closed, closed_next;

  logic        good, good_close, broken, run_idle, is_digit;
  logic [31:0] good_code;
  logic [1:0]  n;
  strike_t     s0, s1;
  result_t     r0, r1;

  function automatic strike_t do_strike(input logic [2:0] cnt, input logic [2:0] lim);
    logic [3:0] nxt;
    strike_t    res;
    nxt         = {1'b0, cnt} + 4'd1;
    res.closing = nxt > {1'b0, lim};
    res.count   = nxt[3] ? 3'd7 : nxt[2:0];
    return res;
  endfunction

  function automatic logic [30:0] sat_add(input logic [30:0] base, input logic [7:0] c);
    logic [31:0] sum;
    sum = {1'b0, base} + {28'd0, c[3:0]};
    return sum[31] ? SUM_MAX : sum[30:0];
  endfunction

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

  always_comb begin
    mode_next    = mode;
    pos_next     = pos;
    total_next   = total;
    strikes_next = strikes;
    closed_next  = closed;
    good         = 1'b0;
    good_close   = 1'b0;
    good_code    = 32'd0;
    broken       = 1'b0;
    run_idle     = 1'b0;
    n            = 2'd0;
    s0           = '0;
    s1           = '0;
    r0           = '0;
    r1           = '0;

    if (!closed) begin
      unique case (mode)
        MODE_UPTIME: begin
          if (rx_byte == CH_P && pos == 3'd1) pos_next = 3'd2;
          else if (rx_byte == CH_T && pos == 3'd2) pos_next = 3'd3;
          else if (rx_byte == CH_I && pos == 3'd3) pos_next = 3'd4;
          else if (rx_byte == CH_M && pos == 3'd4) pos_next = 3'd5;
          else if (rx_byte == CH_E && pos == 3'd5) begin
            good      = 1'b1;
            good_code = {1'b0, uptime_seconds};
          end else broken = 1'b1;
        end
        MODE_LOAD: begin
          if (rx_byte == CH_O && pos == 3'd1) pos_next = 3'd2;
          else if (rx_byte == CH_A && pos == 3'd2) pos_next = 3'd3;
          else if (rx_byte == CH_D && pos == 3'd3) begin
            good      = 1'b1;
            good_code = {16'd0, connection_count};
          end else broken = 1'b1;
        end
        MODE_EXIT: begin
          if (rx_byte == CH_X && pos == 3'd1) pos_next = 3'd2;
          else if (rx_byte == CH_I && pos == 3'd2) pos_next = 3'd3;
          else if (rx_byte == CH_T && pos == 3'd3) begin
            good       = 1'b1;
            good_close = 1'b1;
          end else broken = 1'b1;
        end
        MODE_DIGIT: begin
          if (is_digit) begin
            total_next = sat_add(total, rx_byte);
          end else if (rx_byte == CH_SPACE) begin
            good       = 1'b1;
            good_code  = {1'b0, total};
            total_next = 31'd0;
          end else begin
            total_next = 31'd0;
            broken     = 1'b1;
          end
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      if (good) begin
        strikes_next     = 3'd0;
        mode_next        = MODE_IDLE;
        pos_next         = 3'd0;
        closed_next      = good_close;
        r0.reply_code    = good_code;
        r0.close_session = good_close;
        n                = 2'd1;
      end

      // Broken word: strike, then re-parse the same byte from idle unless closing
      if (broken) begin
        mode_next        = MODE_IDLE;
        pos_next         = 3'd0;
        s0               = do_strike(strikes, strike_limit);
        strikes_next     = s0.count;
        r0.reply_code    = '1;
        r0.close_session = s0.closing;
        n                = 2'd1;
        if (s0.closing) closed_next = 1'b1;
        else run_idle = 1'b1;
      end

      if (run_idle) begin
        mode_next = MODE_IDLE;
        pos_next  = 3'd0;
        if (rx_byte == CH_U) begin
          mode_next = MODE_UPTIME;
          pos_next  = 3'd1;
        end else if (rx_byte == CH_L) begin
          mode_next = MODE_LOAD;
          pos_next  = 3'd1;
        end else if (rx_byte == CH_E) begin
          mode_next = MODE_EXIT;
          pos_next  = 3'd1;
        end else if (is_digit) begin
          mode_next  = MODE_DIGIT;
          total_next = sat_add(total_next, rx_byte);
        end else begin
          s1           = do_strike(strikes_next, strike_limit);
          strikes_next = s1.count;
          if (s1.closing) closed_next = 1'b1;
          if (n == 2'd0) begin
            r0.reply_code    = '1;
            r0.close_session = s1.closing;
          end else begin
            r1.reply_code    = '1;
            r1.close_session = s1.closing;
          end
          n = n + 2'd1;
        end
      end
    end

    r0.last_reply = (n == 2'd1);
    r1.last_reply = 1'b1;
  end

  assign push.count = accept ? n : 2'd0;
  assign push.res0  = r0;
  assign push.res1  = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      pos     <= 3'd0;
      total   <= 31'd0;
      strikes <= 3'd0;
      closed  <= 1'b0;
    end else if (accept) begin
      mode    <= mode_next;
      pos     <= pos_next;
      total   <= total_next;
      strikes <= strikes_next;
      closed  <= closed_next;
    end
  end

  // Once closed, the session stays closed until reset
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    closed |=> closed)
    else $error("session reopened without reset");

  a_closed_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && closed) |-> (push.count == 2'd0))
    else $error("result produced after session close");

  // A second reply only follows a non-closing strike
  a_two_replies: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |->
      (push.res0.reply_code == -32'sd1 && !push.res0.close_session && !push.res0.last_reply))
    else $error("bad first reply of a pair");

endmodule

FILE: src/cmdkw_reply_queue.sv
// Reply queue: up to two results in per push, one out per ready cycle.
module cmdkw_reply_queue
  import cmdkw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  push_t                 push,
  output logic                  has_room,
  cmdkw_reply_if.source         reply
);

  result_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;
  result_t          head;

  assign has_room = count <= PUSH_ROOM;
  assign pop      = reply.valid && reply.ready;

  assign count_next = count + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.res0;
    if (push.count == 2'd2) mem[wr_ptr + PTR_W'(1)] <= push.res1;
  end

  assign head                = mem[rd_ptr];
  assign reply.valid         = count != '0;
  assign reply.reply_code    = head.reply_code;
  assign reply.close_session = head.close_session;
  assign reply.last_reply    = head.last_reply;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("reply queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= PUSH_ROOM))
    else $error("push without room");

endmodule

FILE: src/command_keyword_parser_core.sv
// Command keyword parser: top level.
// Replies are registered in the reply queue and offered in order from its head; bytes
// are taken one per cycle while the queue has room. Two replies of one byte leave singly
// from the single-read reply queue (four entries, input held when fewer than two free).
// Reset (rst, synchronous): parser idle, strikes cleared, session open,
// strike limit 2, reply queue empty.
module command_keyword_parser_core
  import cmdkw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  cmdkw_rx_if.sink           rx,
  cmdkw_reply_if.source      reply
);

  logic [2:0] strike_limit;
  logic       has_room;
  logic       accept;
  push_t      push;

  assign rx.ready = has_room;
  assign accept   = rx.valid && has_room;

  cmdkw_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .strike_limit (strike_limit)
  );

  cmdkw_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .rx_byte          (rx.rx_byte),
    .uptime_seconds   (rx.uptime_seconds),
    .connection_count (rx.connection_count),
    .strike_limit     (strike_limit),
    .push             (push)
  );

  cmdkw_reply_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .has_room (has_room),
    .reply    (reply)
  );

endmodule

FILE: bench/command_keyword_parser_core_checker.sv
// Reply checker for the command keyword parser: predicts replies per byte and compares.
`timescale 1ns / 100ps

module command_keyword_parser_core_checker
  import cmdkw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  cmdkw_rx_if                rx,
  cmdkw_reply_if             reply,
  output int unsigned        fail_count,
  output int unsigned        replies_waiting,
  output int unsigned        replies_seen
);

  localparam logic [PADDR_W-1:0] STRIKE_LIMIT_ADDR = {REG_STRIKE_LIMIT, 2'b00};

  mode_t       cur_mode;
  logic [2:0]  word_pos;
  logic [30:0] digit_sum;
  logic [2:0]  strike_run;
  logic [2:0]  strike_max;
  logic        shut;
  result_t     reply_expect_q[$];
  result_t     byte_replies[2];
  int          n_new;
  int unsigned errors = 0;
  int unsigned seen   = 0;

  task automatic note_reply(input logic signed [31:0] code, input logic closing);
    byte_replies[n_new] = '{reply_code: code, close_session: closing, last_reply: 1'b0};
    n_new++;
  endtask

  // Count the strike before saturating it, so limit 7 shuts on the eighth.
  task automatic take_strike();
    logic [3:0] nxt;
    logic       closing;
    nxt        = {1'b0, strike_run} + 4'd1;
    closing    = nxt > {1'b0, strike_max};
    strike_run = (nxt > 4'd7) ? 3'd7 : nxt[2:0];
    if (closing) shut = 1'b1;
    note_reply(-32'sd1, closing);
  endtask

  task automatic close_word(input logic signed [31:0] code, input logic closing);
    strike_run = '0;
    cur_mode   = MODE_IDLE;
    word_pos   = '0;
    if (closing) shut = 1'b1;
    note_reply(code, closing);
  endtask

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic add_digit(input logic [7:0] c);
    logic [31:0] total;
    total     = {1'b0, digit_sum} + 32'(c - CH_ZERO);
    digit_sum = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[30:0];
  endtask

  task automatic start_word(input logic [7:0] c);
    if (c == CH_U) begin
      cur_mode = MODE_UPTIME;
      word_pos = 3'd1;
    end else if (c == CH_L) begin
      cur_mode = MODE_LOAD;
      word_pos = 3'd1;
    end else if (c == CH_E) begin
      cur_mode = MODE_EXIT;
      word_pos = 3'd1;
    end else if (is_digit(c)) begin
      cur_mode = MODE_DIGIT;
      word_pos = '0;
      add_digit(c);
    end else begin
      take_strike();
    end
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic [30:0] up,
                            input logic [15:0] conn);
    logic broken;
    broken = 1'b0;
    n_new  = 0;
    if (shut) return;
    case (cur_mode)
      MODE_UPTIME: begin
        if (c == CH_P && word_pos == 3'd1) word_pos = 3'd2;
        else if (c == CH_T && word_pos == 3'd2) word_pos = 3'd3;
        else if (c == CH_I && word_pos == 3'd3) word_pos = 3'd4;
        else if (c == CH_M && word_pos == 3'd4) word_pos = 3'd5;
        else if (c == CH_E && word_pos == 3'd5) close_word({1'b0, up}, 1'b0);
        else broken = 1'b1;
      end
      MODE_LOAD: begin
        if (c == CH_O && word_pos == 3'd1) word_pos = 3'd2;
        else if (c == CH_A && word_pos == 3'd2) word_pos = 3'd3;
        else if (c == CH_D && word_pos == 3'd3) close_word({16'd0, conn}, 1'b0);
        else broken = 1'b1;
      end
      MODE_EXIT: begin
        if (c == CH_X && word_pos == 3'd1) word_pos = 3'd2;
        else if (c == CH_I && word_pos == 3'd2) word_pos = 3'd3;
        else if (c == CH_T && word_pos == 3'd3) close_word('0, 1'b1);
        else broken = 1'b1;
      end
      MODE_DIGIT: begin
        if (is_digit(c)) begin
          add_digit(c);
        end else if (c == CH_SPACE) begin
          close_word({1'b0, digit_sum}, 1'b0);
          digit_sum = '0;
        end else begin
          digit_sum = '0;
          broken    = 1'b1;
        end
      end
      default: begin
        cur_mode = MODE_IDLE;
        word_pos = '0;
        start_word(c);
      end
    endcase
    // A breaking byte is parsed again from idle unless its strike shut the session
    if (broken) begin
      cur_mode = MODE_IDLE;
      word_pos = '0;
      take_strike();
      if (!shut) start_word(c);
    end
    for (int k = 0; k < n_new; k++) begin
      if (k == n_new - 1) byte_replies[k].last_reply = 1'b1;
      reply_expect_q.push_back(byte_replies[k]);
    end
  endtask

  task automatic flag_field(input string field, input logic signed [31:0] want,
                            input logic signed [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic check_reply();
    result_t want;
    seen++;
    if (reply_expect_q.size() == 0) begin
      errors++;
      $display("%0t: reply with none expected, expected nothing, got code %0d close %0b last %0b",
               $time, reply.reply_code, reply.close_session, reply.last_reply);
      return;
    end
    want = reply_expect_q.pop_front();
    if (reply.reply_code !== want.reply_code)
      flag_field("reply_code", want.reply_code, reply.reply_code);
    if (reply.close_session !== want.close_session)
      flag_field("close_session", 32'(want.close_session), 32'(reply.close_session));
    if (reply.last_reply !== want.last_reply)
      flag_field("last_reply", 32'(want.last_reply), 32'(reply.last_reply));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_mode   = MODE_IDLE;
      word_pos   = '0;
      digit_sum  = '0;
      strike_run = '0;
      strike_max = STRIKE_LIMIT_RESET;
      shut       = 1'b0;
      reply_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == STRIKE_LIMIT_ADDR)
        strike_max = pwdata[2:0];
      // Retire replies before predicting, since a reply never shares the edge of its byte
      if (reply.valid && reply.ready) check_reply();
      if (rx.valid && rx.ready)
        parse_byte(rx.rx_byte, rx.uptime_seconds, rx.connection_count);
    end
    fail_count      <= errors;
    replies_waiting <= reply_expect_q.size();
    replies_seen    <= seen;
  end

endmodule

FILE: bench/command_keyword_parser_core_tb.sv
// Testbench top for the command keyword parser: byte stimulus, register writes and verdict.
`timescale 1ns / 100ps

module command_keyword_parser_core_tb;
  import cmdkw_pkg::*;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;
  typedef enum {SHUT_BY_EXIT, SHUT_BY_STRIKES, SHUT_BY_BROKEN_WORD} shut_e;

  localparam logic [PADDR_W-1:0] STRIKE_LIMIT_ADDR = {REG_STRIKE_LIMIT, 2'b00};
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BYTES = 100;
  localparam int unsigned N_PHASES    = 10;
  localparam logic [2:0]  LIMIT_PLAN [N_PHASES] =
    '{3'd7, 3'd0, 3'd5, 3'd1, 3'd7, 3'd3, 3'd6, 3'd2, 3'd4, 3'd7};

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int unsigned        fail_count;
  int unsigned        replies_waiting;
  int unsigned        replies_seen;
  int unsigned        bytes_sent;
  bit                 quiet;
  bit                 squeeze;
  shut_e              how_shut;
  string              noise_pool = "uleptimoadx 059";

  cmdkw_rx_if    rx_ch();
  cmdkw_reply_if reply_ch();

  command_keyword_parser_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx_ch),
    .reply   (reply_ch)
  );

  command_keyword_parser_core_checker watch (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .rx              (rx_ch),
    .reply           (reply_ch),
    .fail_count      (fail_count),
    .replies_waiting (replies_waiting),
    .replies_seen    (replies_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("command_keyword_parser_core_tb: FAIL");
    $finish;
  end

  // Reply side: random stalls, one long hold-off once squeeze is raised
  initial begin
    bit held;
    held = 1'b0;
    reply_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze && !held) begin
        held = 1'b1;
        reply_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        reply_ch.ready <= quiet || ($urandom_range(0, 99) >= 8);
        @(posedge clk);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input fill_e fill = FILL_RANDOM);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    case (fill)
      FILL_ZERO: begin
        rx_ch.uptime_seconds   <= '0;
        rx_ch.connection_count <= '0;
      end
      FILL_ONES: begin
        rx_ch.uptime_seconds   <= '1;
        rx_ch.connection_count <= '1;
      end
      default: begin
        rx_ch.uptime_seconds   <= 31'($urandom());
        rx_ch.connection_count <= 16'($urandom());
      end
    endcase
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input fill_e fill = FILL_RANDOM);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], fill);
  endtask

  function automatic logic [7:0] no_start_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_U || b == CH_L || b == CH_E || (b >= CH_ZERO && b <= CH_NINE));
    return b;
  endfunction

  task automatic send_noise(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 255)));
      else put_byte(noise_pool[$urandom_range(0, noise_pool.len() - 1)]);
    end
  endtask

  // Never exit here: it would shut the session for the rest of the run
  task automatic send_command();
    int unsigned len;
    case ($urandom_range(0, 2))
      0: send_text("uptime");
      1: send_text("load");
      default: begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
        repeat (len) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        put_byte(CH_SPACE);
      end
    endcase
  endtask

  task automatic write_strike_limit(input logic [2:0] lim);
    rx_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (replies_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= STRIKE_LIMIT_ADDR;
    pwdata  <= ($urandom() & ~32'h7) | 32'(lim);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned target;
    int unsigned drain;
    int unsigned lim;
    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    rx_ch.valid            <= 1'b0;
    rx_ch.rx_byte          <= '0;
    rx_ch.uptime_seconds   <= '0;
    rx_ch.connection_count <= '0;
    quiet      = 1'b0;
    squeeze    = 1'b0;
    bytes_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed opening at the reset strike limit; the strike run never exceeds two
    put_byte(8'h00);
    put_byte(8'hFF);
    send_text("uptime", FILL_ONES);
    send_text("lox");
    send_text("9 ");
    send_text("12uptime", FILL_ZERO);
    send_text("exload", FILL_ONES);

    // Noise of n bytes plus the next command's first byte gives at most 2n+1 strikes
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_strike_limit(LIMIT_PLAN[ph]);
      lim   = LIMIT_PLAN[ph];
      quiet = (ph == 4);
      if (ph == 2) squeeze = 1'b1;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        send_noise(lim == 0 ? 0 : $urandom_range(0, (lim - 1) / 2));
        send_command();
      end
    end
    quiet = 1'b0;

    how_shut = shut_e'($urandom_range(0, 2));
    case (how_shut)
      SHUT_BY_EXIT: begin
        write_strike_limit(3'($urandom_range(0, 7)));
        send_text("exit");
      end
      SHUT_BY_STRIKES: begin
        write_strike_limit(3'd7);
        repeat (8) put_byte(no_start_byte());
      end
      default: begin
        write_strike_limit(3'd1);
        put_byte(no_start_byte());
        put_byte(CH_U);
        put_byte(CH_SPACE);
      end
    endcase
    // The shut session must stay silent
    repeat (12) put_byte(8'($urandom_range(0, 255)));
    rx_ch.valid <= 1'b0;

    repeat (2) @(posedge clk);
    drain = 0;
    while (replies_waiting != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes and checked %0d replies over strike limits 0 to 7,",
             bytes_sent, replies_seen);
    $display("including a long reply hold-off; session shut by %s.", how_shut.name());
    if (fail_count == 0 && replies_waiting == 0) begin
      $display("command_keyword_parser_core_tb: PASS");
    end else begin
      $display("command_keyword_parser_core_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: command_keyword_parser_core.f
src/cmdkw_pkg.sv
src/cmdkw_rx_if.sv
src/cmdkw_reply_if.sv
src/cmdkw_regs.sv
src/cmdkw_parser.sv
src/cmdkw_reply_queue.sv
src/command_keyword_parser_core.sv
bench/command_keyword_parser_core_checker.sv
bench/command_keyword_parser_core_tb.sv
